### src/hdw_pkg.sv
// Shared constants and the interpolation helper for the height-map warp.
`default_nettype none
package hdw_pkg;

    localparam int MAP_SIZE = 256;
    localparam int IDX_W    = $clog2(MAP_SIZE);
    localparam int ADDR_W   = $clog2(MAP_SIZE * MAP_SIZE);
    localparam int SX_W     = 16 + IDX_W;   // 8.16 sample point in table space
    localparam int N_TAPS   = 8;            // cells of the neighbourhood actually used

    localparam logic [15:0] HALF_FX = 16'h8000;

    localparam logic KIND_WARP  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    localparam logic MODE_CURL = 1'b0;
    localparam logic MODE_GRAD = 1'b1;

    typedef logic [15:0] t_height;

    // a + floor((b - a) * f / 65536), equal to (a*(1-f) + b*f) >> 16
    function automatic t_height lerp(input t_height a, input t_height b,
                                     input logic [15:0] f);
        logic signed [16:0] diff;
        logic signed [33:0] prod;
        logic signed [17:0] sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = 34'(diff) * $signed({18'd0, f});
        sum  = $signed({2'b00, a}) + 18'(prod >>> 16);
        return sum[15:0];
    endfunction

endpackage
`default_nettype wire

### src/heightmap_displacement_warp_top.sv
// Height-map displacement warp: five-stage pipeline with replicated height table.
//
//  channel | signals                                   | direction | accepted when
//  --------+-------------------------------------------+-----------+----------------------
//  in      | i_kind i_coord_x/y i_table_row/col        | in        | i_valid & o_ready
//          | i_height_value                            |           |
//  out     | o_warped_x o_warped_y                     | out       | o_valid & i_ready
//  cfg     | i_cfg_we i_cfg_data (warp_mode)           | in        | i_cfg_we
//
// One item per cycle while the output is not stalled; a warp item passes
// scale, table read, row lerp, column lerp and gradient/sum in order. Table writes
// complete at the edge that takes them and give no result.
// Eight copies of the table, one read port each, serve the neighbourhood
// in a single read; every write goes to all copies.
// Synchronous active-low reset clears the valid bits and warp_mode; the
// table stays undefined until written. A stalled output freezes the whole
// pipe, so nothing is dropped or repeated.
`default_nettype none
module heightmap_displacement_warp_top
    import hdw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic signed [30:0] i_coord_x,
    input  wire logic signed [30:0] i_coord_y,
    input  wire logic [7:0]         i_table_row,
    input  wire logic [7:0]         i_table_col,
    input  wire logic [15:0]        i_height_value,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_warped_x,
    output logic signed [31:0]      o_warped_y,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_data
);

    logic r_mode;
    logic en;

    // stage valids (warp items only)
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;

    // stage 1: scaled sample point
    logic [SX_W-1:0]    r_s1_sx, r_s1_sy;
    logic signed [30:0] r_s1_x, r_s1_y;

    // stage 2: table taps
    t_height            r_s2_c [N_TAPS];
    logic [15:0]        r_s2_fx, r_s2_fy;
    logic signed [30:0] r_s2_x, r_s2_y;

    // stage 3: row lerps
    t_height            r_s3_h [5];
    logic [15:0]        r_s3_fy;
    logic signed [30:0] r_s3_x, r_s3_y;

    // stage 4: bilinear samples
    t_height            r_s4_p, r_s4_pr, r_s4_pd;
    logic signed [30:0] r_s4_x, r_s4_y;

    logic [15:0]        frac_x, frac_y;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr [N_TAPS];
    logic [IDX_W-1:0]   ci, ri;
    logic signed [16:0] gx, gy;
    logic signed [31:0] x_ext, y_ext, gx_ext, gy_ext;
    logic signed [31:0] n_wx, n_wy;

    // whole pipe advances unless a finished result is waiting
    assign en      = !r_s5_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_s5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CURL;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid && (i_kind == KIND_WARP);
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
    end

    // fraction plus half, wrapped to 16 bits
    assign frac_x = i_coord_x[15:0] + HALF_FX;
    assign frac_y = i_coord_y[15:0] + HALF_FX;

    // stage 1: wrapped fraction scaled by MAP_SIZE-2
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sx <= SX_W'(frac_x) * SX_W'(MAP_SIZE - 2);
            r_s1_sy <= SX_W'(frac_y) * SX_W'(MAP_SIZE - 2);
            r_s1_x  <= i_coord_x;
            r_s1_y  <= i_coord_y;
        end
    end

    // table write at the accepting edge; reads of older items see old data
    assign wr_en   = en && i_valid && (i_kind == KIND_WRITE)
                     && (int'(i_table_row) < MAP_SIZE) && (int'(i_table_col) < MAP_SIZE);
    assign wr_addr = ADDR_W'(int'(i_table_row) * MAP_SIZE + int'(i_table_col));

    assign ci = r_s1_sx[16 +: IDX_W];
    assign ri = r_s1_sy[16 +: IDX_W];

    // taps: rows ri..ri+2, cols ci..ci+2, bottom-right corner unused
    always_comb begin
        rd_addr[0] = ADDR_W'(int'(ri) * MAP_SIZE + int'(ci));
        rd_addr[1] = ADDR_W'(int'(ri) * MAP_SIZE + int'(ci) + 1);
        rd_addr[2] = ADDR_W'(int'(ri) * MAP_SIZE + int'(ci) + 2);
        rd_addr[3] = ADDR_W'((int'(ri) + 1) * MAP_SIZE + int'(ci));
        rd_addr[4] = ADDR_W'((int'(ri) + 1) * MAP_SIZE + int'(ci) + 1);
        rd_addr[5] = ADDR_W'((int'(ri) + 1) * MAP_SIZE + int'(ci) + 2);
        rd_addr[6] = ADDR_W'((int'(ri) + 2) * MAP_SIZE + int'(ci));
        rd_addr[7] = ADDR_W'((int'(ri) + 2) * MAP_SIZE + int'(ci) + 1);
    end

    // stage 2: one table copy per tap
    for (genvar k = 0; k < N_TAPS; k++) begin : g_copy
        t_height mem [MAP_SIZE * MAP_SIZE];

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                mem[wr_addr] <= i_height_value;
            end
            if (en) begin
                r_s2_c[k] <= mem[rd_addr[k]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_fx <= r_s1_sx[15:0];
            r_s2_fy <= r_s1_sy[15:0];
            r_s2_x  <= r_s1_x;
            r_s2_y  <= r_s1_y;
        end
    end

    // stage 3: horizontal lerps (row ri+1 left pair is shared by p and pd)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_h[0] <= lerp(r_s2_c[0], r_s2_c[1], r_s2_fx);
            r_s3_h[1] <= lerp(r_s2_c[3], r_s2_c[4], r_s2_fx);
            r_s3_h[2] <= lerp(r_s2_c[1], r_s2_c[2], r_s2_fx);
            r_s3_h[3] <= lerp(r_s2_c[4], r_s2_c[5], r_s2_fx);
            r_s3_h[4] <= lerp(r_s2_c[6], r_s2_c[7], r_s2_fx);
            r_s3_fy   <= r_s2_fy;
            r_s3_x    <= r_s2_x;
            r_s3_y    <= r_s2_y;
        end
    end

    // stage 4: vertical lerps
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_p  <= lerp(r_s3_h[0], r_s3_h[1], r_s3_fy);
            r_s4_pr <= lerp(r_s3_h[2], r_s3_h[3], r_s3_fy);
            r_s4_pd <= lerp(r_s3_h[1], r_s3_h[4], r_s3_fy);
            r_s4_x  <= r_s3_x;
            r_s4_y  <= r_s3_y;
        end
    end

    // stage 5: gradients and displacement
    assign gx     = $signed({1'b0, r_s4_p}) - $signed({1'b0, r_s4_pr});
    assign gy     = $signed({1'b0, r_s4_p}) - $signed({1'b0, r_s4_pd});
    assign x_ext  = 32'(r_s4_x);
    assign y_ext  = 32'(r_s4_y);
    assign gx_ext = 32'(gx);
    assign gy_ext = 32'(gy);

    always_comb begin
        if (r_mode == MODE_CURL) begin
            n_wx = x_ext + (gy_ext >>> 1) + (gx_ext >>> 4);
            n_wy = y_ext - (gx_ext >>> 1) + (gy_ext >>> 4);
        end else begin
            n_wx = x_ext + (gx_ext >>> 1);
            n_wy = y_ext + (gy_ext >>> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_warped_x <= n_wx;
            o_warped_y <= n_wy;
        end
    end

endmodule
`default_nettype wire
